>>> rtl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

  localparam int unsigned FrameBytesDefault = 9;
  localparam int unsigned CountW = 4;
  localparam int unsigned TempW = 16;

  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteOnes = 8'hFF;

  localparam logic signed [TempW-1:0] LowLimitReset = 16'(-55 * 16);
  localparam logic signed [TempW-1:0] HighLimitReset = 16'(125 * 16);

  // register indexes
  localparam logic RegLowLimit = 1'b0;
  localparam logic RegHighLimit = 1'b1;

  // result status codes
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBlank = 2'd1;
  localparam logic [1:0] StatusCrcBad = 2'd2;
  localparam logic [1:0] StatusRange = 2'd3;

  typedef struct packed {
    logic last;
    logic [1:0] status;
    logic signed [TempW-1:0] temp;
  } frame_res_t;

  // reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic mix;
    crc = crc_in;
    b = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = {1'b0, b[7:1]};
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ssc_frame.sv
`default_nettype none

module ssc_frame #(
  parameter int unsigned FRAME_BYTES = ssc_pkg::FrameBytesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic [7:0] byte_in,
  input  wire logic signed [ssc_pkg::TempW-1:0] low_limit,
  input  wire logic signed [ssc_pkg::TempW-1:0] high_limit,
  output ssc_pkg::frame_res_t res
);

  localparam logic [ssc_pkg::CountW-1:0] LastIdx = ssc_pkg::CountW'(FRAME_BYTES - 1);

  logic [ssc_pkg::CountW-1:0] byte_count;
  logic [7:0] crc_acc;
  logic all_zero_seen;
  logic all_ones_seen;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_high_byte;

  logic is_last;
  logic zero_next;
  logic ones_next;
  logic signed [ssc_pkg::TempW-1:0] temp_raw;
  logic [1:0] status_sel;

  assign is_last = (byte_count == LastIdx);
  assign zero_next = all_zero_seen && (byte_in == ssc_pkg::ByteZero);
  assign ones_next = all_ones_seen && (byte_in == ssc_pkg::ByteOnes);
  assign temp_raw = {temp_high_byte, temp_low_byte};

  always_comb begin
    priority if (zero_next || ones_next) begin
      status_sel = ssc_pkg::StatusBlank;
    end else if (crc_acc != byte_in) begin
      status_sel = ssc_pkg::StatusCrcBad;
    end else if (temp_raw < low_limit || temp_raw > high_limit) begin
      status_sel = ssc_pkg::StatusRange;
    end else begin
      status_sel = ssc_pkg::StatusOk;
    end
  end

  assign res.last = is_last;
  assign res.status = status_sel;
  assign res.temp = (status_sel == ssc_pkg::StatusOk) ? temp_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_acc <= '0;
      all_zero_seen <= 1'b1;
      all_ones_seen <= 1'b1;
      temp_low_byte <= '0;
      temp_high_byte <= '0;
    end else if (step) begin
      if (is_last) begin
        byte_count <= '0;
        crc_acc <= '0;
        all_zero_seen <= 1'b1;
        all_ones_seen <= 1'b1;
        temp_low_byte <= '0;
        temp_high_byte <= '0;
      end else begin
        byte_count <= byte_count + 1'b1;
        crc_acc <= ssc_pkg::crc8_byte(crc_acc, byte_in);
        all_zero_seen <= zero_next;
        all_ones_seen <= ones_next;
        if (byte_count == '0) begin
          temp_low_byte <= byte_in;
        end
        if (byte_count == ssc_pkg::CountW'(1)) begin
          temp_high_byte <= byte_in;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LastIdx)
    else $error("byte count ran past frame end");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    step && is_last |=> byte_count == '0 && crc_acc == '0 && all_zero_seen && all_ones_seen)
    else $error("frame state not cleared after last byte");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    step && !is_last |=> byte_count == $past(byte_count) + 1'b1)
    else $error("byte count did not advance");

endmodule

`default_nettype wire

>>> rtl/sensor_scratchpad_crc_checker.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// input    | in_valid / in_ready     | scratch_byte[7:0]
// result   | out_valid / out_ready   | status[1:0], temperature[15:0] signed
// config   | cfg_write               | cfg_index, cfg_data[15:0]
//
// One byte a cycle sustained while results are taken. A byte waits in the input
// register, then the frame logic folds it into the CRC and flags; the last byte of
// a frame is checked against them instead and loads the result register when it
// advances, so a result passes the input and then the result register.
// The input register stalls only when a last byte meets a result not yet taken.
// rst (synchronous) clears the frame state, the limits to -880 and 2000, and
// both valid flags.
`default_nettype none

module sensor_scratchpad_crc_checker #(
  parameter int unsigned FRAME_BYTES = ssc_pkg::FrameBytesDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [7:0] scratch_byte,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic signed [ssc_pkg::TempW-1:0] temperature,
  input  wire logic cfg_write,
  input  wire logic cfg_index,
  input  wire logic [ssc_pkg::TempW-1:0] cfg_data
);

  // limit registers
  logic signed [ssc_pkg::TempW-1:0] low_limit;
  logic signed [ssc_pkg::TempW-1:0] high_limit;

  // input register
  logic byte_valid;
  logic [7:0] byte_q;

  ssc_pkg::frame_res_t res;
  logic advance;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= ssc_pkg::LowLimitReset;
      high_limit <= ssc_pkg::HighLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssc_pkg::RegLowLimit: low_limit <= cfg_data;
        ssc_pkg::RegHighLimit: high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // result slot is free if empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  // held byte moves on unless it closes a frame and the result slot is busy
  assign advance = byte_valid && (!res.last || out_free);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= scratch_byte;
    end
  end

  ssc_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .byte_in(byte_q),
    .low_limit(low_limit),
    .high_limit(high_limit),
    .res(res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.last) begin
      status <= res.status;
      temperature <= res.temp;
    end
  end

  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ssc_pkg::StatusOk |-> temperature == '0)
    else $error("temperature not zero on failed status");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && res.last))
    else $error("result overwritten before it was taken");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !advance |=> byte_valid && $stable(byte_q))
    else $error("held byte lost while stalled");

endmodule

`default_nettype wire
